// File: hw/rtl/scu_pkg.sv
`default_nettype none

package scu_pkg;

	localparam int BLOCK_WORDS = 112;
	localparam int NUM_CH      = 1728;
	localparam int CH_W        = 11;
	localparam int VAL_W       = 40;
	localparam int CNT_W       = 6;
	localparam int PW_W        = 8;
	localparam int BLK_W       = 6;
	localparam int HDR_WORDS   = 38;
	localparam logic [15:0] SECOND_HALF_MODE = 16'd322;

	// result status codes
	localparam logic [1:0] ST_DATA      = 2'd0;
	localparam logic [1:0] ST_BAD_MODE  = 2'd1;
	localparam logic [1:0] ST_BAD_HALF  = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	// internal mode codes
	localparam logic [2:0] M_NONE = 3'd0;
	localparam logic [2:0] M_111  = 3'd1;
	localparam logic [2:0] M_211  = 3'd2;
	localparam logic [2:0] M_312  = 3'd3;
	localparam logic [2:0] M_411  = 3'd4;
	localparam logic [2:0] M_511  = 3'd5;
	localparam logic [2:0] M_611  = 3'd6;
	localparam logic [2:0] M_711  = 3'd7;

	// one work packet from the front end to the emitter
	typedef struct packed {
		logic              err;
		logic [1:0]        status;
		logic [CH_W-1:0]   start;
		logic [CNT_W-1:0]  cnt;
		logic [VAL_W-1:0]  value;
	} job_t;

	typedef logic [15:0] ln_tab_t [11];
	localparam ln_tab_t LN_THRESH = '{16'd3, 16'd8, 16'd21, 16'd55, 16'd149, 16'd404,
		16'd1097, 16'd2981, 16'd8104, 16'd22027, 16'd59875};

	function automatic logic [2:0] decode_mode(input logic [15:0] w);
		logic [2:0] m;
		case (w)
			16'd111: m = M_111;
			16'd211: m = M_211;
			16'd312: m = M_312;
			16'd411: m = M_411;
			16'd511: m = M_511;
			16'd611: m = M_611;
			16'd711: m = M_711;
			default: m = M_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] shift_of(input logic [15:0] r);
		logic [3:0] s;
		s = 4'd1;
		for (int i = 0; i < 11; i++) begin
			if (r >= LN_THRESH[i]) s = s + 4'd1;
		end
		if (r == 16'd0) s = 4'd0;
		return s;
	endfunction

	function automatic logic [3:0] band_of(input logic [15:0] w);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 7; i >= 0; i--) begin
			if (w[3+i]) n = 4'(i);
		end
		return n;
	endfunction

	function automatic logic [BLK_W:0] blocks_of(input logic [2:0] m);
		logic [BLK_W:0] n;
		case (m)
			M_111:   n = 7'd16;
			M_211:   n = 7'd16;
			M_312:   n = 7'd32;
			M_411:   n = 7'd8;
			M_511:   n = 7'd3;
			M_611:   n = 7'd5;
			M_711:   n = 7'd5;
			default: n = 7'd1;
		endcase
		return n;
	endfunction

	function automatic logic [PW_W-1:0] data_start(input logic [2:0] m,
		input logic [BLK_W-1:0] b);
		logic [PW_W-1:0] s;
		case (m)
			M_NONE:       s = PW_W'(HDR_WORDS);
			M_111, M_211: s = (b == '0) ? PW_W'(HDR_WORDS + 14) : '0;
			M_312: begin
				if (b == '0) s = PW_W'(HDR_WORDS + 28);
				else if (b[3:0] == 4'd0) s = PW_W'(HDR_WORDS);
				else s = '0;
			end
			default:      s = (b == '0) ? PW_W'(HDR_WORDS + 4) : '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scu_if.sv
`default_nettype none

// word channel into the unpacker
interface scu_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] tm_word;
	logic        scan_start;

	modport source (output valid, tm_word, scan_start, input ready);
	modport sink (input valid, tm_word, scan_start, output ready);
endinterface

// result channel out of the unpacker
interface scu_out_if;
	logic                      valid;
	logic                      ready;
	logic [scu_pkg::CH_W-1:0]  channel_index;
	logic [scu_pkg::VAL_W-1:0] channel_value;
	logic [1:0]                status;
	logic                      last;

	modport source (output valid, channel_index, channel_value, status, last, input ready);
	modport sink (input valid, channel_index, channel_value, status, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/scu_front.sv
`default_nettype none

module scu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [15:0]   tm_word,
	input  wire logic          scan_start,
	input  wire logic          q_full,
	output logic               push,
	output scu_pkg::job_t      push_job
);

	typedef enum logic {S_IDLE, S_DIV} state_t;

	state_t                      state_q;
	logic                        pair_order_q;
	logic [2:0]                  mode_q;
	logic                        active_q;
	logic [3:0]                  shift_q;
	logic [3:0]                  band_q;
	logic [scu_pkg::BLK_W-1:0]   blk_q;
	logic [scu_pkg::PW_W-1:0]    pos_q;
	logic [scu_pkg::CH_W-1:0]    cc_q;
	logic [15:0]                 held_q;
	logic                        hp_q;
	logic [31:0]                 dd_q;
	scu_pkg::job_t               job_q;

	logic                        acc;
	logic                        act_e, hp_e;
	logic [2:0]                  mode_e, mode_n;
	logic [3:0]                  shift_n, band_n;
	logic [scu_pkg::BLK_W-1:0]   b;
	logic [scu_pkg::PW_W-1:0]    p;
	logic [scu_pkg::CH_W-1:0]    cc_e, cc_n, left;
	logic [2:0]                  dec;
	logic                        err1, err2, exh, indata, have, emit, done_c, wrap;
	logic [31:0]                 readout;
	logic [scu_pkg::CNT_W-1:0]   copies, cnt;
	logic [2:0]                  shr;
	logic                        d24;
	logic [10:0]                 lo;
	logic [scu_pkg::PW_W:0]      pn;
	logic [scu_pkg::BLK_W:0]     bn;
	logic [scu_pkg::VAL_W-1:0]   scaled;
	scu_pkg::job_t               job_c;
	logic                        push_now, start_div, div_end;
	logic [63:0]                 prod;
	logic [30:0]                 quo;
	logic [31:0]                 diff;
	logic [scu_pkg::VAL_W-1:0]   dval;

	assign acc      = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !q_full;

	// classify the incoming word against the scan state
	always_comb begin
		act_e  = scan_start ? 1'b1 : active_q;
		mode_e = scan_start ? scu_pkg::M_NONE : mode_q;
		hp_e   = scan_start ? 1'b0 : hp_q;
		b      = scan_start ? '0 : blk_q;
		p      = scan_start ? '0 : pos_q;
		cc_e   = scan_start ? '0 : cc_q;
		shift_n = scan_start ? 4'd0 : shift_q;
		band_n  = scan_start ? 4'd0 : band_q;
		dec    = scu_pkg::decode_mode(tm_word);
		mode_n = mode_e;
		err1   = 1'b0;
		if (b == '0 && p == 8'd1) begin
			mode_n = dec;
			err1   = act_e && (dec == scu_pkg::M_NONE);
		end
		if (b == '0 && p == 8'd15) band_n = scu_pkg::band_of(tm_word);
		if (b == '0 && p == 8'd35) shift_n = scu_pkg::shift_of(tm_word);
		err2 = act_e && !err1 && mode_n == scu_pkg::M_312 && b == 6'd16 && p == 8'd1
			&& tm_word != scu_pkg::SECOND_HALF_MODE;
		indata = act_e && !err1 && !err2 && (p >= scu_pkg::data_start(mode_n, b));
		have   = (mode_n == scu_pkg::M_111) ? indata : (indata && hp_e);
		if (mode_n == scu_pkg::M_111) readout = {16'd0, tm_word} << shift_n;
		else if (pair_order_q) readout = {tm_word, held_q};
		else readout = {held_q, tm_word};
		emit = have && (cc_e < scu_pkg::CH_W'(scu_pkg::NUM_CH));

		// replication zone of the current channel
		copies = 6'd1;
		shr    = 3'd0;
		d24    = 1'b0;
		lo     = {band_n, 7'd0} + {1'b0, band_n, 6'd0};
		case (mode_n)
			scu_pkg::M_211: copies = 6'd2;
			scu_pkg::M_411: begin
				if (cc_e < 11'd24 || cc_e >= 11'd1704) begin
					copies = 6'd8; shr = 3'd3;
				end else begin
					copies = 6'd4; shr = 3'd2;
				end
			end
			scu_pkg::M_511: begin
				if (cc_e < 11'd800 || cc_e >= 11'd928) begin
					copies = 6'd32; shr = 3'd5;
				end else if (cc_e < 11'd832 || cc_e >= 11'd896) begin
					copies = 6'd2; shr = 3'd1;
				end
			end
			scu_pkg::M_611: begin
				if (cc_e < 11'd98 || cc_e >= 11'd1630) begin
					copies = 6'd1;
				end else if (cc_e < 11'd112 || cc_e >= 11'd1616) begin
					copies = 6'd2; shr = 3'd1;
				end else begin
					copies = 6'd32; shr = 3'd5;
				end
			end
			scu_pkg::M_711: begin
				if (!(cc_e >= lo && {1'b0, cc_e} < {1'b0, lo} + 12'd192)) begin
					copies = 6'd24; d24 = 1'b1;
				end
			end
			default: copies = 6'd1;
		endcase
		left   = scu_pkg::CH_W'(scu_pkg::NUM_CH) - cc_e;
		cnt    = ({5'd0, copies} < left) ? copies : left[scu_pkg::CNT_W-1:0];
		cc_n   = cc_e + {5'd0, cnt};
		done_c = emit && (cc_n >= scu_pkg::CH_W'(scu_pkg::NUM_CH));
		pn     = {1'b0, p} + 9'd1;
		wrap   = pn >= (scu_pkg::PW_W+1)'(scu_pkg::BLOCK_WORDS);
		bn     = {1'b0, b} + 7'd1;
		exh    = act_e && !err1 && !err2 && !done_c && wrap
			&& (bn >= scu_pkg::blocks_of(mode_n));
		scaled = {readout, 8'd0} >> shr;

		job_c.err    = err1 || err2 || exh;
		job_c.status = err1 ? scu_pkg::ST_BAD_MODE :
			(err2 ? scu_pkg::ST_BAD_HALF : (exh ? scu_pkg::ST_EXHAUSTED : scu_pkg::ST_DATA));
		job_c.start  = cc_e;
		job_c.cnt    = cnt;
		job_c.value  = scaled;
		push_now  = acc && (job_c.err || (emit && !d24));
		start_div = acc && !job_c.err && emit && d24;
	end

	// divide the held readout by three with a reciprocal multiply
	always_comb begin
		prod    = {32'd0, dd_q} * {32'd0, 32'hAAAA_AAAB};
		quo     = prod[63:33];
		diff    = dd_q - ({quo, 1'b0} + {1'b0, quo});
		div_end = (state_q == S_DIV);
		dval    = {4'd0, quo, 5'd0} + ((diff[1:0] == 2'd2) ? 40'd21 :
			((diff[1:0] == 2'd1) ? 40'd10 : 40'd0));
	end

	always_comb begin
		push     = push_now || div_end;
		push_job = job_c;
		if (state_q == S_DIV) begin
			push_job       = job_q;
			push_job.value = dval;
		end
	end

	// hold the scan state and the divide sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pair_order_q <= 1'b0;
			mode_q       <= scu_pkg::M_NONE;
			active_q     <= 1'b0;
			shift_q      <= '0;
			band_q       <= '0;
			blk_q        <= '0;
			pos_q        <= '0;
			cc_q         <= '0;
			hp_q         <= 1'b0;
		end else begin
			if (cfg_we) pair_order_q <= cfg_wdata;
			if (acc && act_e) begin
				mode_q  <= mode_n;
				shift_q <= shift_n;
				band_q  <= band_n;
				if (emit) cc_q <= cc_n;
				else cc_q <= cc_e;
				if (indata && mode_n != scu_pkg::M_111) hp_q <= !hp_e;
				else hp_q <= hp_e;
				if (err1 || err2 || exh || done_c) begin
					active_q <= 1'b0;
					hp_q     <= 1'b0;
				end else begin
					active_q <= 1'b1;
					if (wrap) begin
						pos_q <= '0;
						blk_q <= bn[scu_pkg::BLK_W-1:0];
					end else begin
						pos_q <= pn[scu_pkg::PW_W-1:0];
						blk_q <= b;
					end
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start_div) state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc && indata && mode_n != scu_pkg::M_111 && !hp_e) held_q <= tm_word;
		if (start_div) begin
			job_q <= job_c;
			dd_q  <= readout;
		end
	end

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !in_ready)
		else $error("word taken during divide");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		start_div |=> (state_q == S_DIV))
		else $error("divide did not start");

endmodule

`default_nettype wire

// File: hw/rtl/scu_fifo.sv
`default_nettype none

module scu_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire scu_pkg::job_t  push_job,
	input  wire logic           pop,
	output scu_pkg::job_t       head,
	output logic                empty,
	output logic                full
);

	scu_pkg::job_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = mem_q[rp_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");

endmodule

`default_nettype wire

// File: hw/rtl/scu_back.sv
`default_nettype none

module scu_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire scu_pkg::job_t  head,
	input  wire logic           empty,
	output logic                pop,
	scu_out_if.source           res
);

	logic [scu_pkg::CNT_W-1:0] idx_q;
	logic                      load;
	logic [scu_pkg::CH_W-1:0]  ch;

	assign load = !res.valid || res.ready;
	assign ch   = head.start + {5'd0, idx_q};
	assign pop  = load && !empty && (head.err || (idx_q + 6'd1 == head.cnt));

	// step through the copies of the head packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
			idx_q     <= '0;
		end else if (load) begin
			res.valid <= !empty;
			if (!empty) begin
				if (pop) idx_q <= '0;
				else idx_q <= idx_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (head.err) begin
				res.channel_index <= '0;
				res.channel_value <= '0;
				res.status        <= head.status;
				res.last          <= 1'b1;
			end else begin
				res.channel_index <= ch;
				res.channel_value <= head.value;
				res.status        <= scu_pkg::ST_DATA;
				res.last          <= (ch == scu_pkg::CH_W'(scu_pkg::NUM_CH - 1));
			end
		end
	end

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != scu_pkg::ST_DATA) |-> (res.last && res.channel_index == '0))
		else $error("malformed error word");

endmodule

`default_nettype wire

// File: hw/rtl/spectrometer_channel_unpacker.sv
`default_nettype none

// Spectrometer channel unpacker.
// word_ch carries 16-bit telemetry words with scan_start marking word zero of a
// scan; result_ch carries channel words (channel_index, channel_value with 8
// fraction bits, status, last). cfg_we/cfg_wdata set pair_order.
// The front end takes one word per cycle, unless the queue is full or a divide
// is running, and classifies it; a readout that falls outside the mode 711
// window is divided by 24 with a shift and a reciprocal multiply in the S_DIV
// state, during which the word channel is held. Each word yields at most one
// packet into a two-entry queue; the emitter expands a packet into its copies,
// one result word per cycle while result_ch is ready. A result passes through
// the queue and the output register, a divided readout also through S_DIV.
// Error results (unknown mode, bad second half, blocks exhausted) carry index 0
// and last set, and end the scan.
// Reset clears the scan state, empties the queue, drops result valid and sets
// pair_order to 0. When result_ch stalls the queue fills and word_ch.ready
// falls; nothing is lost.

module spectrometer_channel_unpacker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	scu_in_if.sink      word_ch,
	scu_out_if.source   result_ch
);

	scu_pkg::job_t push_job, head;
	logic          push, pop, empty, full;

	scu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (word_ch.valid),
		.in_ready   (word_ch.ready),
		.tm_word    (word_ch.tm_word),
		.scan_start (word_ch.scan_start),
		.q_full     (full),
		.push       (push),
		.push_job   (push_job)
	);

	scu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	scu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.res    (result_ch)
	);

endmodule

`default_nettype wire

// File: tb/tb_spectrometer_channel_unpacker.sv
`timescale 1ns / 100ps

module tb_spectrometer_channel_unpacker;

	typedef struct {
		logic [scu_pkg::CH_W-1:0]  idx;
		logic [scu_pkg::VAL_W-1:0] val;
		logic [1:0]                st;
		logic                      lst;
	} chan_word_t;

	localparam int SCAN_BLOCKS_MAX = 32;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	scu_in_if  in_ch ();
	scu_out_if out_ch ();

	spectrometer_channel_unpacker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.word_ch   (in_ch),
		.result_ch (out_ch)
	);

	// expected channel words, oldest first
	chan_word_t chan_q[$];

	int err_cnt;
	int word_cnt;
	int chan_cnt;
	int scan_cnt;
	int out_hold;
	bit calm;

	// unpacker state as predicted
	logic             lo_first;
	logic [2:0]       sc_mode;
	bit               sc_active;
	logic [3:0]       sc_shift;
	logic [3:0]       sc_band;
	int               sc_blk;
	int               sc_pos;
	int               sc_chan;
	logic [15:0]      sc_held;
	bit               sc_pend;

	const logic [15:0] LN_STEPS [11] = '{16'd3, 16'd8, 16'd21, 16'd55, 16'd149, 16'd404,
		16'd1097, 16'd2981, 16'd8104, 16'd22027, 16'd59875};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		err_cnt++;
	endtask

	function automatic logic [2:0] mode_from_word(input logic [15:0] w);
		case (w)
			16'd111: return scu_pkg::M_111;
			16'd211: return scu_pkg::M_211;
			16'd312: return scu_pkg::M_312;
			16'd411: return scu_pkg::M_411;
			16'd511: return scu_pkg::M_511;
			16'd611: return scu_pkg::M_611;
			16'd711: return scu_pkg::M_711;
			default: return scu_pkg::M_NONE;
		endcase
	endfunction

	function automatic int scan_blocks(input logic [2:0] m);
		case (m)
			scu_pkg::M_111, scu_pkg::M_211:  return 16;
			scu_pkg::M_312:                  return 32;
			scu_pkg::M_411:                  return 8;
			scu_pkg::M_511:                  return 3;
			scu_pkg::M_611, scu_pkg::M_711:  return 5;
			default:                         return 1;
		endcase
	endfunction

	function automatic int first_data_word(input int b);
		if (sc_mode == scu_pkg::M_NONE) return scu_pkg::HDR_WORDS;
		if (sc_mode == scu_pkg::M_111 || sc_mode == scu_pkg::M_211)
			return (b == 0) ? scu_pkg::HDR_WORDS + 14 : 0;
		if (sc_mode == scu_pkg::M_312) begin
			if (b == 0) return scu_pkg::HDR_WORDS + 28;
			return (b % 16 == 0) ? scu_pkg::HDR_WORDS : 0;
		end
		return (b == 0) ? scu_pkg::HDR_WORDS + 4 : 0;
	endfunction

	function automatic void push_error(input logic [1:0] st);
		chan_word_t e;
		e.idx = '0;
		e.val = '0;
		e.st  = st;
		e.lst = 1'b1;
		chan_q.push_back(e);
		sc_active = 0;
		sc_pend   = 0;
	endfunction

	// replication and divisor of the readout landing on channel k
	function automatic void zone_of(input int k, output int copies, output int div);
		int lo;
		copies = 1;
		div    = 1;
		case (sc_mode)
			scu_pkg::M_211: copies = 2;
			scu_pkg::M_411: begin
				if (k < 24 || k >= 1704) begin copies = 8; div = 8; end
				else begin copies = 4; div = 4; end
			end
			scu_pkg::M_511: begin
				if (k < 800 || k >= 928) begin copies = 32; div = 32; end
				else if (k < 832 || k >= 896) begin copies = 2; div = 2; end
			end
			scu_pkg::M_611: begin
				if (k < 98 || k >= 1630) copies = 1;
				else if (k < 112 || k >= 1616) begin copies = 2; div = 2; end
				else begin copies = 32; div = 32; end
			end
			scu_pkg::M_711: begin
				lo = sc_band * 192;
				if (!(k >= lo && k < lo + 192)) begin copies = 24; div = 24; end
			end
			default: ;
		endcase
	endfunction

	// advance the predicted state by one accepted word
	function automatic void predict_word(input logic [15:0] w, input logic start);
		int b, p, copies, div, n, i;
		logic [63:0] readout, value;
		bit have;
		chan_word_t e;
		have = 0;
		readout = '0;
		if (start) begin
			sc_active = 1;
			sc_mode   = scu_pkg::M_NONE;
			sc_shift  = '0;
			sc_band   = '0;
			sc_blk    = 0;
			sc_pos    = 0;
			sc_chan   = 0;
			sc_pend   = 0;
		end
		if (!sc_active) return;
		b = sc_blk;
		p = sc_pos;
		// capture header fields of block zero
		if (b == 0) begin
			if (p == 1) begin
				sc_mode = mode_from_word(w);
				if (sc_mode == scu_pkg::M_NONE) begin
					push_error(scu_pkg::ST_BAD_MODE);
					return;
				end
			end else if (p == 15) begin
				sc_band = 4'd8;
				for (i = 7; i >= 0; i--) if (w[3+i]) sc_band = 4'(i);
			end else if (p == 35) begin
				sc_shift = 4'd0;
				if (w != 0) begin
					sc_shift = 4'd1;
					for (i = 0; i < 11; i++) if (w >= LN_STEPS[i]) sc_shift++;
				end
			end
		end
		if (sc_mode == scu_pkg::M_312 && b == 16 && p == 1
			&& w != scu_pkg::SECOND_HALF_MODE) begin
			push_error(scu_pkg::ST_BAD_HALF);
			return;
		end
		// build the readout
		if (p >= first_data_word(b)) begin
			if (sc_mode == scu_pkg::M_111) begin
				readout = 64'(w) << sc_shift;
				have = 1;
			end else if (!sc_pend) begin
				sc_held = w;
				sc_pend = 1;
			end else begin
				readout = lo_first ? {32'd0, w, sc_held} : {32'd0, sc_held, w};
				sc_pend = 0;
				have = 1;
			end
		end
		// emit the copies
		if (have && sc_chan < scu_pkg::NUM_CH) begin
			zone_of(sc_chan, copies, div);
			n = scu_pkg::NUM_CH - sc_chan;
			if (copies < n) n = copies;
			value = (readout << 8) / div;
			for (i = 0; i < n; i++) begin
				e.idx = scu_pkg::CH_W'(sc_chan);
				e.val = value[scu_pkg::VAL_W-1:0];
				e.st  = scu_pkg::ST_DATA;
				e.lst = (sc_chan == scu_pkg::NUM_CH - 1);
				chan_q.push_back(e);
				sc_chan++;
			end
			if (sc_chan >= scu_pkg::NUM_CH) begin
				sc_active = 0;
				sc_pend   = 0;
				return;
			end
		end
		p++;
		if (p >= scu_pkg::BLOCK_WORDS) begin
			p = 0;
			b++;
			if (b >= scan_blocks(sc_mode)) begin
				push_error(scu_pkg::ST_EXHAUSTED);
				return;
			end
		end
		sc_pos = p;
		sc_blk = b;
	endfunction

	// hand one word to the unpacker and predict on acceptance
	task automatic send_word(input logic [15:0] w, input logic start);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		for (int i = 0; i < gap; i++) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.valid      = 1'b1;
		in_ch.tm_word    = w;
		in_ch.scan_start = start;
		do @(posedge clk); while (!in_ch.ready);
		predict_word(w, start);
		word_cnt++;
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_ch.valid      = 1'b0;
		in_ch.scan_start = 1'b0;
	endtask

	// let every outstanding word arrive, then allow the divider to settle
	task automatic drain();
		go_quiet();
		wait (chan_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_pair_order(input logic v);
		drain();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		lo_first  = v;
	endtask

	function automatic logic [15:0] pick_data(input bit extreme);
		int r;
		r = $urandom_range(0, 9);
		if (extreme || r == 0) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		return 16'($urandom_range(0, 65535));
	endfunction

	// one scan: header fields as given, the rest random; stops after max_words or at scan end
	task automatic run_scan(input logic [15:0] mode_w, input logic [15:0] band_w,
		input logic [15:0] count_w, input logic [15:0] half_w, input int max_words,
		input bit extreme);
		int q, b, p;
		logic [15:0] w;
		scan_cnt++;
		q = 0;
		do begin
			b = q / scu_pkg::BLOCK_WORDS;
			p = q % scu_pkg::BLOCK_WORDS;
			if (b == 0 && p == 1) w = mode_w;
			else if (b == 0 && p == 15) w = band_w;
			else if (b == 0 && p == 35) w = count_w;
			else if (b == 16 && p == 1) w = half_w;
			else w = pick_data(extreme);
			send_word(w, q == 0);
			q++;
		end while (q < max_words && sc_active && q < SCAN_BLOCKS_MAX * scu_pkg::BLOCK_WORDS);
	endtask

	function automatic logic [15:0] pick_band();
		case ($urandom_range(0, 3))
			0:       return 16'h0000;
			1:       return 16'(1 << (3 + $urandom_range(0, 7)));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// check each accepted channel word against the oldest expectation
	always @(posedge clk) begin
		chan_word_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			chan_cnt++;
			if (chan_q.size() == 0) begin
				report($sformatf("unexpected word idx %0d st %0d",
					out_ch.channel_index, out_ch.status));
			end else begin
				e = chan_q.pop_front();
				if (out_ch.channel_index !== e.idx)
					report($sformatf("index %0d, want %0d", out_ch.channel_index, e.idx));
				if (out_ch.channel_value !== e.val)
					report($sformatf("value %h at %0d, want %h", out_ch.channel_value,
						e.idx, e.val));
				if (out_ch.status !== e.st)
					report($sformatf("status %0d at %0d, want %0d", out_ch.status,
						e.idx, e.st));
				if (out_ch.last !== e.lst)
					report($sformatf("last %0d at %0d, want %0d", out_ch.last, e.idx, e.lst));
			end
			out_hold = calm ? 0 : $urandom_range(0, 3);
		end
	end

	// back-pressure on the result side
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_hold > 0) begin
				out_ch.ready = 1'b0;
				out_hold--;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	task automatic test_idle_words();
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'd111, 1'b0);
	endtask

	task automatic test_bad_mode();
		run_scan(16'd0, 0, 0, 0, 3, 0);
		run_scan(16'd322, 0, 0, 0, 3, 0);
		run_scan(16'hFFFF, 0, 0, 0, 3, 0);
		send_word(16'h1234, 1'b0);
	endtask

	task automatic test_abandon_and_extremes();
		// cut each scan short; the next start abandons it
		run_scan(16'd111, 16'h0000, 16'hFFFF, 0, 54, 1);
		run_scan(16'd211, 16'hFFFF, 16'd0, 0, 56, 1);
	endtask

	task automatic test_swapped_pairs();
		set_pair_order(1'b1);
		run_scan(16'd711, pick_band(), 16'd3, 0, 46, 0);
		calm = 1;
		run_scan(16'd411, 16'h0000, 16'd0, 0, 46, 1);
		calm = 0;
	endtask

	initial begin
		err_cnt  = 0;
		word_cnt = 0;
		chan_cnt = 0;
		scan_cnt = 0;
		out_hold = 0;
		calm     = 0;
		lo_first = 1'b0;
		sc_mode  = scu_pkg::M_NONE;
		sc_active = 0;
		sc_pend  = 0;
		sc_held  = '0;
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.tm_word    = '0;
		in_ch.scan_start = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_words();
		test_bad_mode();
		test_abandon_and_extremes();
		test_swapped_pairs();

		drain();
		$display("covered %0d scans, %0d words in, %0d channel words out",
			scan_cnt, word_cnt, chan_cnt);
		$display("both pair orders, modes 111, 211, 411 and 711, header errors, abandoned scans");
		if (err_cnt == 0) begin
			$display("spectrometer_channel_unpacker verification clean");
		end else begin
			$display("spectrometer_channel_unpacker verification failed");
		end
		$finish;
	end

	// hard stop in case the unpacker hangs
	initial begin
		#20_000_000;
		$display("timeout with %0d channel words outstanding", chan_q.size());
		$display("spectrometer_channel_unpacker verification failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/scu_pkg.sv
hw/rtl/scu_if.sv
hw/rtl/scu_front.sv
hw/rtl/scu_fifo.sv
hw/rtl/scu_back.sv
hw/rtl/spectrometer_channel_unpacker.sv
tb/tb_spectrometer_channel_unpacker.sv
